// File: rtl/core/gdce_pkg.sv
// Shared types, constants and helpers for the gamepad dead zone event block.
`timescale 1ns / 1ps
package gdce_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int NUM_AXES   = 6;
  localparam int NUM_BTNS   = 14;
  localparam int NUM_EVTS   = NUM_AXES + NUM_BTNS;

  localparam logic [14:0] FULL_SCALE  = 15'd32767;
  localparam logic [7:0]  TRIG_FULL   = 8'd255;
  localparam logic [23:0] MAG_CLIP    = 24'(32767 * 256);
  localparam logic [15:0] TWICE_FULL  = 16'(2 * 32767);

  localparam logic [14:0] LDZ_RESET = 15'd7849;
  localparam logic [14:0] RDZ_RESET = 15'd8689;
  localparam logic [7:0]  TH_RESET  = 8'd30;

  // register indexes on the config port
  localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
  localparam logic [1:0] REG_RIGHT_DZ = 2'd1;
  localparam logic [1:0] REG_TRIG_TH  = 2'd2;

  localparam logic KIND_AXIS   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  typedef struct packed {
    logic        done;
    logic [15:0] x;
    logic [15:0] y;
  } stick_res_t;

  typedef struct packed {
    logic        done;
    logic [15:0] val;
  } trig_res_t;

  typedef struct packed {
    logic [1:0]  slot;
    logic        kind;
    logic [3:0]  code;
    logic [15:0] value;
    logic        last;
  } event_t;

  // button code -> bit in the raw word (bits 10 and 11 are unmapped)
  function automatic logic [3:0] btn_bit(input logic [3:0] code);
    logic [3:0] b;
    b = (code < 4'd10) ? code : 4'(code + 4'd2);
    return b;
  endfunction

endpackage

// File: rtl/core/gamepad_deadzone_change_events.sv
// Top level: config registers, sample intake, four lanes and the event merge.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_ready_o  | slot, buttons, sticks, triggers
//  out     | out | out_valid_o/out_ready_i| event_slot/kind/code/value, last_event
//  cfg     | in  | psel/penable/pready    | paddr, pwdata, prdata
//
// A stick lane runs two squares, 24 root steps, two multiply states, a numerator
// state and 16 divide steps; a stick in its dead zone ends after the first multiply
// state. A trigger lane runs at most 16 divide steps. When the lanes finish, the
// change mask is registered, then the first word enters the output register; words
// leave one per cycle, up to 20, while out_ready_i is high. in_ready_o rises in the
// cycle after the last word of the previous sample enters the output register.
// Reset restores the register defaults and clears all history.
`timescale 1ns / 1ps
module gamepad_deadzone_change_events (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         slot_i,
  input  logic [15:0]        buttons_i,
  input  logic signed [15:0] left_x_i,
  input  logic signed [15:0] left_y_i,
  input  logic signed [15:0] right_x_i,
  input  logic signed [15:0] right_y_i,
  input  logic [7:0]         left_trigger_i,
  input  logic [7:0]         right_trigger_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_slot_o,
  output logic               event_kind_o,
  output logic [3:0]         event_code_o,
  output logic signed [15:0] event_value_o,
  output logic               last_event_o
);
  import gdce_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_e;

  state_e      state_q;
  logic [14:0] ldz_q, rdz_q;
  logic [7:0]  th_q;
  logic [1:0]  slot_q;
  logic [15:0] btn_q;

  logic       accept, start, wr, lanes_done, load, busy;
  stick_res_t lres, rres;
  trig_res_t  ltres, rtres;
  event_t     evt;
  logic [5:0][15:0] axis;

  assign accept = in_valid_i && in_ready_o;
  assign start  = accept && (32'(slot_i) < SLOT_COUNT);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign in_ready_o = state_q == ST_IDLE;
  assign lanes_done = lres.done && rres.done && ltres.done && rtres.done;
  assign load   = (state_q == ST_RUN) && lanes_done;
  assign axis   = {rtres.val, ltres.val, rres.y, rres.x, lres.y, lres.x};

  always_comb begin
    unique case (paddr[3:2])
      REG_LEFT_DZ:  prdata = {17'h0, ldz_q};
      REG_RIGHT_DZ: prdata = {17'h0, rdz_q};
      REG_TRIG_TH:  prdata = {24'h0, th_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldz_q <= LDZ_RESET;
      rdz_q <= RDZ_RESET;
      th_q  <= TH_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_LEFT_DZ:  ldz_q <= pwdata[14:0];
        REG_RIGHT_DZ: rdz_q <= pwdata[14:0];
        REG_TRIG_TH:  th_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            slot_q  <= slot_i;
            btn_q   <= buttons_i;
            state_q <= ST_RUN;
          end
        end
        ST_RUN:  if (lanes_done) state_q <= ST_EMIT;
        ST_EMIT: if (!busy) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  gdce_stick_lane u_left (
    .clk_i, .rst_ni, .start_i(start), .x_i(left_x_i), .y_i(left_y_i),
    .dz_i(ldz_q), .res_o(lres)
  );
  gdce_stick_lane u_right (
    .clk_i, .rst_ni, .start_i(start), .x_i(right_x_i), .y_i(right_y_i),
    .dz_i(rdz_q), .res_o(rres)
  );
  gdce_trig_lane u_ltrig (
    .clk_i, .rst_ni, .start_i(start), .t_i(left_trigger_i), .th_i(th_q), .res_o(ltres)
  );
  gdce_trig_lane u_rtrig (
    .clk_i, .rst_ni, .start_i(start), .t_i(right_trigger_i), .th_i(th_q), .res_o(rtres)
  );

  gdce_merge u_merge (
    .clk_i, .rst_ni, .load_i(load), .slot_i(slot_q), .buttons_i(btn_q),
    .axis_i(axis), .busy_o(busy), .out_valid_o, .out_ready_i, .evt_o(evt)
  );

  assign event_slot_o  = evt.slot;
  assign event_kind_o  = evt.kind;
  assign event_code_o  = evt.code;
  assign event_value_o = evt.value;
  assign last_event_o  = evt.last;

endmodule

// File: rtl/core/gdce_stick_lane.sv
// One thumbstick lane: radial dead zone via bit-serial root and two dividers.
`timescale 1ns / 1ps
module gdce_stick_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [15:0]   x_i,
  input  logic signed [15:0]   y_i,
  input  logic [14:0]          dz_i,
  output gdce_pkg::stick_res_t res_o
);
  import gdce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_ROOT, S_MUL1, S_MUL2, S_NUM, S_DIV
  } state_e;

  state_e      state_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic        sx_q, sy_q;
  logic [15:0] ax_q, ay_q;
  logic [14:0] dz_q;
  logic [31:0] sum_q;
  logic [47:0] rad_q;
  logic [27:0] rem_q;
  logic [23:0] root_q;
  logic [23:0] diff_q;
  logic [38:0] den_q;
  logic [39:0] px_q, py_q;
  logic [39:0] dv_q;
  logic [39:0] rx_q, ry_q;
  logic [15:0] nlx_q, nly_q;
  logic [15:0] qx_q, qy_q;

  logic [27:0] rem_sh, trial;
  logic [23:0] mag_c, dz_s;
  logic [56:0] num_x, num_y;
  logic [40:0] shx, shy;
  logic        gex, gey;

  always_comb begin
    rem_sh = {rem_q[25:0], rad_q[47:46]};
    trial  = {2'b00, root_q, 2'b01};
    mag_c  = (root_q > MAG_CLIP) ? MAG_CLIP : root_q;
    dz_s   = {1'b0, dz_q, 8'h00};
    // 2*32767*p + den = (p << 16) - (p << 1) + den
    num_x  = 57'({px_q, 16'h0000}) - 57'({px_q, 1'b0}) + 57'(den_q);
    num_y  = 57'({py_q, 16'h0000}) - 57'({py_q, 1'b0}) + 57'(den_q);
    shx    = {rx_q, nlx_q[15]};
    shy    = {ry_q, nly_q[15]};
    gex    = shx >= {1'b0, dv_q};
    gey    = shy >= {1'b0, dv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            done_q  <= 1'b0;
            sx_q    <= x_i[15];
            sy_q    <= y_i[15];
            ax_q    <= x_i[15] ? 16'(-x_i) : 16'(x_i);
            ay_q    <= y_i[15] ? 16'(-y_i) : 16'(y_i);
            dz_q    <= dz_i;
            state_q <= S_SQX;
          end
        end
        S_SQX: begin
          sum_q   <= ax_q * ax_q;
          state_q <= S_SQY;
        end
        S_SQY: begin
          rad_q   <= {32'(sum_q + ay_q * ay_q), 16'h0000};
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= 5'd23;
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          rad_q <= {rad_q[45:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[22:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[22:0], 1'b0};
          end
          if (cnt_q == 5'd0) state_q <= S_MUL1;
          cnt_q <= cnt_q - 5'd1;
        end
        S_MUL1: begin
          diff_q <= mag_c - dz_s;
          den_q  <= root_q * (FULL_SCALE - dz_q);
          if (mag_c <= dz_s) begin
            qx_q    <= '0;
            qy_q    <= '0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MUL2;
          end
        end
        S_MUL2: begin
          px_q    <= ax_q * diff_q;
          py_q    <= ay_q * diff_q;
          dv_q    <= {den_q, 1'b0};
          state_q <= S_NUM;
        end
        S_NUM: begin
          // quotient fits 16 bits, so the upper part is already below the divisor
          rx_q    <= num_x[55:16];
          ry_q    <= num_y[55:16];
          nlx_q   <= num_x[15:0];
          nly_q   <= num_y[15:0];
          qx_q    <= '0;
          qy_q    <= '0;
          cnt_q   <= 5'd15;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rx_q  <= gex ? 40'(shx - {1'b0, dv_q}) : shx[39:0];
          ry_q  <= gey ? 40'(shy - {1'b0, dv_q}) : shy[39:0];
          nlx_q <= {nlx_q[14:0], 1'b0};
          nly_q <= {nly_q[14:0], 1'b0};
          qx_q  <= {qx_q[14:0], gex};
          qy_q  <= {qy_q[14:0], gey};
          if (cnt_q == 5'd0) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
          cnt_q <= cnt_q - 5'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.done = done_q;
  assign res_o.x    = sx_q ? 16'(-qx_q) : qx_q;
  assign res_o.y    = sy_q ? 16'(-qy_q) : qy_q;

endmodule

// File: rtl/core/gdce_trig_lane.sv
// One trigger lane: threshold and rounded rescale through a serial divider.
`timescale 1ns / 1ps
module gdce_trig_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          t_i,
  input  logic [7:0]          th_i,
  output gdce_pkg::trig_res_t res_o
);
  import gdce_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_NUM, T_DIV} state_e;

  state_e      state_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [7:0]  t_q, th_q;
  logic [8:0]  dv_q;
  logic [8:0]  r_q;
  logic [15:0] nl_q;
  logic [15:0] q_q;

  logic [7:0]  dif, den;
  logic [23:0] num;
  logic [9:0]  sh;
  logic        ge;

  always_comb begin
    dif = t_q - th_q;
    den = TRIG_FULL - th_q;
    num = 24'(dif * TWICE_FULL) + 24'(den);
    sh  = {r_q, nl_q[15]};
    ge  = sh >= {1'b0, dv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        T_IDLE: begin
          if (start_i) begin
            done_q  <= 1'b0;
            t_q     <= t_i;
            th_q    <= th_i;
            state_q <= T_NUM;
          end
        end
        T_NUM: begin
          q_q <= '0;
          if (t_q <= th_q) begin
            done_q  <= 1'b1;
            state_q <= T_IDLE;
          end else begin
            dv_q    <= {den, 1'b0};
            r_q     <= {1'b0, num[23:16]};
            nl_q    <= num[15:0];
            cnt_q   <= 4'd15;
            state_q <= T_DIV;
          end
        end
        T_DIV: begin
          r_q  <= ge ? 9'(sh - {1'b0, dv_q}) : sh[8:0];
          nl_q <= {nl_q[14:0], 1'b0};
          q_q  <= {q_q[14:0], ge};
          if (cnt_q == 4'd0) begin
            done_q  <= 1'b1;
            state_q <= T_IDLE;
          end
          cnt_q <= cnt_q - 4'd1;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign res_o.done = done_q;
  assign res_o.val  = q_q;

endmodule

// File: rtl/core/gdce_merge.sv
// Merge stage: compares lane results with per-slot history and emits change words.
`timescale 1ns / 1ps
module gdce_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [1:0]           slot_i,
  input  logic [15:0]          buttons_i,
  input  logic [5:0][15:0]     axis_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gdce_pkg::event_t     evt_o
);
  import gdce_pkg::*;

  logic [NUM_AXES-1:0][15:0] prev_axis_q [SLOT_COUNT];
  logic [15:0]               prev_btn_q  [SLOT_COUNT];
  logic [NUM_EVTS-1:0]       mask_q;
  logic [NUM_AXES-1:0][15:0] nv_q;
  logic [15:0]               btn_q;
  logic [1:0]                slot_q;
  logic                      ov_q;
  event_t                    evt_q;

  logic [SLOT_W-1:0]   sidx;
  logic [15:0]         chg;
  logic [NUM_EVTS-1:0] new_mask, rest;
  logic [4:0]          sel;
  logic [3:0]          bcode;
  logic                adv;
  event_t              evt_d;

  always_comb begin
    sidx = SLOT_W'(slot_i);
    chg  = buttons_i ^ prev_btn_q[sidx];
    for (int i = 0; i < NUM_AXES; i++) new_mask[i] = prev_axis_q[sidx][i] != axis_i[i];
    for (int j = 0; j < NUM_BTNS; j++) new_mask[NUM_AXES + j] = chg[btn_bit(4'(j))];

    sel = '0;
    for (int i = NUM_EVTS - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = 5'(i);
    end
    rest  = mask_q & ~(NUM_EVTS'(1) << sel);
    bcode = 4'(sel - 5'(NUM_AXES));

    evt_d.slot = slot_q;
    evt_d.last = rest == '0;
    if (sel < 5'(NUM_AXES)) begin
      evt_d.kind  = KIND_AXIS;
      evt_d.code  = sel[3:0];
      evt_d.value = nv_q[sel[2:0]];
    end else begin
      evt_d.kind  = KIND_BUTTON;
      evt_d.code  = bcode;
      evt_d.value = {15'h0000, btn_q[btn_bit(bcode)]};
    end
    adv = (mask_q != '0) && (!ov_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      ov_q   <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        prev_axis_q[s] <= '0;
        prev_btn_q[s]  <= '0;
      end
    end else begin
      if (load_i) begin
        mask_q            <= new_mask;
        nv_q              <= axis_i;
        btn_q             <= buttons_i;
        slot_q            <= slot_i;
        prev_axis_q[sidx] <= axis_i;
        prev_btn_q[sidx]  <= buttons_i;
      end else if (adv) begin
        mask_q <= rest;
      end
      if (adv) begin
        evt_q <= evt_d;
        ov_q  <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign busy_o      = mask_q != '0;
  assign out_valid_o = ov_q;
  assign evt_o       = evt_q;

endmodule

// File: rtl/core/gdce_checker.sv
// Port-level checks on the event stream, bound to the top level.
`timescale 1ns / 1ps
module gdce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        event_kind_o,
  input logic [3:0]  event_code_o,
  input logic [15:0] event_value_o,
  input logic        last_event_o
);
  import gdce_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_value_o)
      && $stable(event_code_o) && $stable(last_event_o))
    else $error("stalled event word changed");

  // samples are worked one at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second sample taken while busy");

  a_axis_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == KIND_AXIS |-> event_code_o <= 4'd5)
    else $error("axis code out of range");

  a_button_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == KIND_BUTTON |->
      event_code_o <= 4'd13 && event_value_o[15:1] == '0)
    else $error("bad button event");

endmodule

bind gamepad_deadzone_change_events gdce_checker u_gdce_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .event_kind_o, .event_code_o, .event_value_o, .last_event_o
);
